// File: rtl/core/oaht_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants of the open addressing hash table.
// ---------------------------------------------------------------------------
package oaht_pkg;

  localparam int CAPACITY  = 256;
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int KEY_BYTES = 8;
  localparam int KEY_W     = 64;
  localparam int KLEN_W    = 4;
  localparam int VAL_W     = 32;
  localparam int HASH_W    = 32;

  localparam logic [1:0] MODE_LOOKUP   = 2'd0;
  localparam logic [1:0] MODE_INSERT   = 2'd1;
  localparam logic [1:0] MODE_INCREASE = 2'd2;
  localparam logic [1:0] MODE_REMOVE   = 2'd3;

  localparam logic [1:0] RES_EXISTED   = 2'd0;
  localparam logic [1:0] RES_INSERTED  = 2'd1;
  localparam logic [1:0] RES_NOT_FOUND = 2'd2;
  localparam logic [1:0] RES_FULL      = 2'd3;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_LIVE  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  typedef struct packed {
    logic [1:0]        st;
    logic [KEY_W-1:0]  key;
    logic [KLEN_W-1:0] len;
    logic [VAL_W-1:0]  value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// File: rtl/core/oaht_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// oaht_if
// Request and result channels of the hash table, valid/ready handshake.
// ---------------------------------------------------------------------------
interface oaht_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     mode;
  logic [oaht_pkg::KEY_W-1:0]     key_bytes;
  logic [oaht_pkg::KLEN_W-1:0]    key_length;
  logic [oaht_pkg::VAL_W-1:0]     value_in;
  modport source (output valid, mode, key_bytes, key_length, value_in, input ready);
  modport sink   (input valid, mode, key_bytes, key_length, value_in, output ready);
endinterface

interface oaht_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [oaht_pkg::SLOT_W-1:0]    slot;
  logic [oaht_pkg::VAL_W-1:0]     value_out;
  logic [oaht_pkg::CNT_W-1:0]     live_entries;
  modport source (output valid, status, slot, value_out, live_entries, input ready);
  modport sink   (input valid, status, slot, value_out, live_entries, output ready);
endinterface
`default_nettype wire

// File: rtl/core/open_addressing_hash_table.sv
`default_nettype none
// ---------------------------------------------------------------------------
// open_addressing_hash_table
// Key-value table with triangular probing and tombstones, one result beat
// per request beat.
// ---------------------------------------------------------------------------
// A request is accepted in S_IDLE, then hashed one valid key byte per step in
// S_HASH with the one-at-a-time hash, and the hash is finished in S_FIN. Each
// probe is a RAM read (S_PROBE), then a compare and write back (S_CHK), with
// 1 to 256 probes; S_DLV hands the result to the output register once that
// register is free. The single entry RAM port pair is why each probe reads
// and then compares in separate steps. Requests are handled one at a time;
// the next one is taken while the previous result beat still waits.
module open_addressing_hash_table (
  input  wire logic clk,
  input  wire logic rst_n,
  oaht_in_if.sink   in_bus,
  oaht_out_if.source out_bus
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HASH  = 3'd1;
  localparam logic [2:0] S_FIN   = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_DLV   = 3'd5;

  localparam int SW = oaht_pkg::SLOT_W;
  localparam int CW = oaht_pkg::CNT_W;
  localparam int VW = oaht_pkg::VAL_W;
  localparam int HW = oaht_pkg::HASH_W;
  localparam int LW = oaht_pkg::KLEN_W;

  logic [2:0]                   state_r, state_nxt;
  logic [1:0]                   mode_r, mode_nxt;
  logic [oaht_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [LW-1:0]                len_r, len_nxt;
  logic [VW-1:0]                val_r, val_nxt;
  logic [LW-1:0]                idx_r, idx_nxt;
  logic [HW-1:0]                hash_r, hash_nxt;
  logic [SW-1:0]                pos_r, pos_nxt;
  logic [SW-1:0]                k_r, k_nxt;
  logic                         tomb_hit_r, tomb_hit_nxt;
  logic [SW-1:0]                tomb_pos_r, tomb_pos_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [1:0]                   res_status_r, res_status_nxt;
  logic [SW-1:0]                res_slot_r, res_slot_nxt;
  logic [VW-1:0]                res_value_r, res_value_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   out_status_r, out_status_nxt;
  logic [SW-1:0]                out_slot_r, out_slot_nxt;
  logic [VW-1:0]                out_value_r, out_value_nxt;
  logic [CW-1:0]                out_count_r, out_count_nxt;
  logic [oaht_pkg::CAPACITY-1:0] valid_r, valid_nxt;

  logic                         we;
  logic [SW-1:0]                waddr;
  oaht_pkg::entry_t             wentry;
  logic [oaht_pkg::ENTRY_W-1:0] rdata;
  oaht_pkg::entry_t             rentry;

  logic [LW-1:0]                len_sat;
  logic [oaht_pkg::KEY_W-1:0]   key_mask;
  logic [7:0]                   cur_byte;
  logic [HW-1:0]                h_a, h_b, h_c;
  logic [HW-1:0]                f_a, f_b, f_c;
  logic [1:0]                   cur_st;
  logic                         hit;
  logic                         last;
  logic [VW-1:0]                sum;

  oaht_ram #(
    .WIDTH (oaht_pkg::ENTRY_W),
    .DEPTH (oaht_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (pos_r),
    .rdata (rdata)
  );

  assign rentry = oaht_pkg::entry_t'(rdata);

  always_comb begin
    len_sat = (in_bus.key_length > LW'(oaht_pkg::KEY_BYTES)) ?
              LW'(oaht_pkg::KEY_BYTES) : in_bus.key_length;
    for (int b = 0; b < oaht_pkg::KEY_BYTES; b++) begin
      key_mask[8*b +: 8] = (LW'(b) < len_sat) ? 8'hFF : 8'h00;
    end
    for (int b = oaht_pkg::KEY_BYTES; b < oaht_pkg::KEY_W / 8; b++) begin
      key_mask[8*b +: 8] = 8'h00;
    end
  end

  assign cur_byte = key_r[8*idx_r[2:0] +: 8];
  assign h_a = hash_r + {{(HW-8){cur_byte[7]}}, cur_byte};
  assign h_b = h_a + (h_a << 10);
  assign h_c = h_b ^ (h_b >> 6);
  assign f_a = hash_r + (hash_r << 3);
  assign f_b = f_a ^ (f_a >> 11);
  assign f_c = f_b + (f_b << 15);

  assign cur_st = valid_r[pos_r] ? rentry.st : oaht_pkg::SLOT_EMPTY;
  assign hit    = (cur_st == oaht_pkg::SLOT_LIVE) && (rentry.len == len_r) &&
                  (rentry.key == key_r);
  assign last   = (k_r == SW'(oaht_pkg::CAPACITY - 1));
  assign sum    = rentry.value + val_r;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    len_nxt        = len_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    hash_nxt       = hash_r;
    pos_nxt        = pos_r;
    k_nxt          = k_r;
    tomb_hit_nxt   = tomb_hit_r;
    tomb_pos_nxt   = tomb_pos_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    valid_nxt      = valid_r;
    we             = 1'b0;
    waddr          = pos_r;
    wentry         = rentry;

    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_bus.valid) begin
          mode_nxt  = in_bus.mode;
          key_nxt   = in_bus.key_bytes & key_mask;
          len_nxt   = len_sat;
          val_nxt   = in_bus.value_in;
          idx_nxt   = '0;
          hash_nxt  = '0;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (idx_r == len_r) begin
          state_nxt = S_FIN;
        end else begin
          hash_nxt = h_c;
          idx_nxt  = idx_r + LW'(1);
        end
      end
      S_FIN: begin
        pos_nxt      = f_c[SW-1:0];
        k_nxt        = '0;
        tomb_hit_nxt = 1'b0;
        tomb_pos_nxt = '0;
        state_nxt    = S_PROBE;
      end
      S_PROBE: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        res_slot_nxt = pos_r;
        state_nxt    = S_DLV;
        if (hit) begin
          res_status_nxt = oaht_pkg::RES_EXISTED;
          res_value_nxt  = rentry.value;
          case (mode_r)
            oaht_pkg::MODE_INCREASE: begin
              we            = 1'b1;
              wentry.value  = sum;
              res_value_nxt = sum;
            end
            oaht_pkg::MODE_REMOVE: begin
              we           = 1'b1;
              wentry.st    = oaht_pkg::SLOT_TOMB;
              wentry.value = '0;
              count_nxt    = count_r - CW'(1);
            end
            default: begin
            end
          endcase
        end else if ((cur_st == oaht_pkg::SLOT_EMPTY) || last) begin
          if ((mode_r == oaht_pkg::MODE_LOOKUP) || (mode_r == oaht_pkg::MODE_REMOVE)) begin
            res_status_nxt = oaht_pkg::RES_NOT_FOUND;
            res_slot_nxt   = '0;
            res_value_nxt  = '0;
          end else if (tomb_hit_r || (cur_st == oaht_pkg::SLOT_TOMB) ||
                       (cur_st == oaht_pkg::SLOT_EMPTY)) begin
            we             = 1'b1;
            waddr          = tomb_hit_r ? tomb_pos_r : pos_r;
            wentry.st      = oaht_pkg::SLOT_LIVE;
            wentry.key     = key_r;
            wentry.len     = len_r;
            wentry.value   = val_r;
            valid_nxt[waddr] = 1'b1;
            count_nxt      = count_r + CW'(1);
            res_status_nxt = oaht_pkg::RES_INSERTED;
            res_slot_nxt   = waddr;
            res_value_nxt  = val_r;
          end else begin
            res_status_nxt = oaht_pkg::RES_FULL;
            res_slot_nxt   = '0;
            res_value_nxt  = '0;
          end
        end else begin
          if ((cur_st == oaht_pkg::SLOT_TOMB) && !tomb_hit_r) begin
            tomb_hit_nxt = 1'b1;
            tomb_pos_nxt = pos_r;
          end
          k_nxt     = k_r + SW'(1);
          pos_nxt   = pos_r + k_r + SW'(1);
          state_nxt = S_PROBE;
        end
      end
      S_DLV: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_value_nxt  = res_value_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      tomb_hit_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      tomb_hit_r  <= tomb_hit_nxt;
    end
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    len_r        <= len_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    hash_r       <= hash_nxt;
    pos_r        <= pos_nxt;
    k_r          <= k_nxt;
    tomb_pos_r   <= tomb_pos_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_bus.ready         = (state_r == S_IDLE);
  assign out_bus.valid        = out_valid_r;
  assign out_bus.status       = out_status_r;
  assign out_bus.slot         = out_slot_r;
  assign out_bus.value_out    = out_value_r;
  assign out_bus.live_entries = out_count_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(oaht_pkg::CAPACITY))
    else $error("live entry count above capacity");

  a_accept_hash: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> (state_r == S_HASH))
    else $error("accepted beat did not start hashing");

  a_write_in_chk: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_CHK))
    else $error("RAM write outside compare step");
`endif

endmodule
`default_nettype wire

// File: rtl/core/oaht_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// oaht_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: tb/oaht_tb_pkg.sv
// ---------------------------------------------------------------------------
// oaht_tb_pkg
// Scoreboard of the hash table testbench: a shadow copy of the slot array
// that predicts each result beat and checks the beats leaving the block.
// ---------------------------------------------------------------------------
package oaht_tb_pkg;
  import oaht_pkg::*;

  typedef struct {
    logic [1:0]       status;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] live;
  } table_result_t;

  class table_scoreboard;
    logic [1:0]        shadow_st[CAPACITY];
    logic [KEY_W-1:0]  shadow_key[CAPACITY];
    logic [KLEN_W-1:0] shadow_len[CAPACITY];
    logic [VAL_W-1:0]  shadow_val[CAPACITY];
    int unsigned       live_count;
    table_result_t     pending[$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       status_seen[4];

    function void clear();
      for (int i = 0; i < CAPACITY; i++) begin
        shadow_st[i] = SLOT_EMPTY;
      end
      live_count = 0;
      mismatches = 0;
      checked = 0;
      for (int i = 0; i < 4; i++) status_seen[i] = 0;
    endfunction

    function logic [31:0] oaat_hash(logic [KEY_W-1:0] k, int len);
      logic [31:0] h;
      logic [31:0] b;
      h = 0;
      for (int i = 0; i < len; i++) begin
        b = {{24{k[8*i+7]}}, k[8*i +: 8]};
        h = h + b;
        h = h + (h << 10);
        h = h ^ (h >> 6);
      end
      h = h + (h << 3);
      h = h ^ (h >> 11);
      h = h + (h << 15);
      return h;
    endfunction

    function int probe_slot(int home, int k);
      return (home + k * (k + 1) / 2) % CAPACITY;
    endfunction

    function bit find_key(int home, logic [KEY_W-1:0] k, int len, output int pos);
      int p;
      pos = 0;
      for (int i = 0; i < CAPACITY; i++) begin
        p = probe_slot(home, i);
        if (shadow_st[p] == SLOT_EMPTY) return 0;
        if (shadow_st[p] == SLOT_LIVE && shadow_len[p] == len && shadow_key[p] == k) begin
          pos = p;
          return 1;
        end
      end
      return 0;
    endfunction

    function logic [1:0] insert_key(int home, logic [KEY_W-1:0] k, int len,
                                    logic [VAL_W-1:0] v, output int pos);
      int p;
      int target;
      bit have_tomb;
      bit have_empty;
      have_tomb = 0;
      have_empty = 0;
      target = 0;
      pos = 0;
      for (int i = 0; i < CAPACITY; i++) begin
        p = probe_slot(home, i);
        if (shadow_st[p] == SLOT_EMPTY) begin
          have_empty = 1;
          if (!have_tomb) target = p;
          break;
        end
        if (shadow_st[p] == SLOT_LIVE && shadow_len[p] == len && shadow_key[p] == k) begin
          pos = p;
          return RES_EXISTED;
        end
        if (shadow_st[p] == SLOT_TOMB && !have_tomb) begin
          have_tomb = 1;
          target = p;
        end
      end
      if (!have_tomb && !have_empty) return RES_FULL;
      shadow_st[target] = SLOT_LIVE;
      shadow_key[target] = k;
      shadow_len[target] = len;
      shadow_val[target] = v;
      live_count++;
      pos = target;
      return RES_INSERTED;
    endfunction

    function void note_request(logic [1:0] mode, logic [KEY_W-1:0] key_in,
                               logic [KLEN_W-1:0] len_in, logic [VAL_W-1:0] v);
      int len;
      int home;
      int pos;
      logic [KEY_W-1:0] k;
      table_result_t r;
      len = (len_in > KEY_BYTES) ? KEY_BYTES : len_in;
      k = (len >= 8) ? key_in : key_in & ((64'd1 << (8 * len)) - 64'd1);
      home = oaat_hash(k, len) % CAPACITY;
      r.value = 0;
      pos = 0;
      case (mode)
        MODE_LOOKUP: begin
          if (find_key(home, k, len, pos)) begin
            r.status = RES_EXISTED;
            r.value = shadow_val[pos];
          end else begin
            r.status = RES_NOT_FOUND;
            pos = 0;
          end
        end
        MODE_INSERT: begin
          r.status = insert_key(home, k, len, v, pos);
          if (r.status != RES_FULL) r.value = shadow_val[pos];
        end
        MODE_INCREASE: begin
          if (find_key(home, k, len, pos)) begin
            shadow_val[pos] = shadow_val[pos] + v;
            r.status = RES_EXISTED;
            r.value = shadow_val[pos];
          end else begin
            r.status = insert_key(home, k, len, v, pos);
            if (r.status != RES_FULL) r.value = shadow_val[pos];
          end
        end
        default: begin
          if (find_key(home, k, len, pos)) begin
            r.value = shadow_val[pos];
            shadow_st[pos] = SLOT_TOMB;
            shadow_val[pos] = 0;
            live_count--;
            r.status = RES_EXISTED;
          end else begin
            r.status = RES_NOT_FOUND;
            pos = 0;
          end
        end
      endcase
      r.slot = pos[SLOT_W-1:0];
      r.live = live_count[CNT_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      checked++;
      status_seen[got.status]++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: status %0d slot %0d value %h live %0d",
                   got.status, got.slot, got.value, got.live);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.slot !== want.slot ||
          got.value !== want.value || got.live !== want.live) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected st %0d slot %0d val %h live %0d, got st %0d slot %0d val %h live %0d",
                   checked, want.status, want.slot, want.value, want.live,
                   got.status, got.slot, got.value, got.live);
      end
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Hash table testbench: directed corner requests, then random request streams
// over a small key pool, a fill to capacity and a drain, with random idling on
// both channels in the pool and fill phases, checked beat by beat by the scoreboard.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import oaht_pkg::*;
  import oaht_tb_pkg::*;

  localparam int POOL = 48;
  localparam int FILL = 270;
  localparam int CYCLE_LIMIT = 5000000;

  logic clk;
  logic rst_n;
  int   src_idle;
  int   snk_idle;
  int   cycles;
  int   sent;

  logic [KEY_W-1:0]  pool_key[POOL];
  int                pool_len[POOL];
  logic [KEY_W-1:0]  fill_key[FILL];
  table_scoreboard   sb;

  oaht_in_if  in_bus ();
  oaht_out_if out_bus ();

  open_addressing_hash_table dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, sb.pending.size());
      $display("** open_addressing_hash_table: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      sb.note_request(in_bus.mode, in_bus.key_bytes, in_bus.key_length, in_bus.value_in);
  end

  always @(posedge clk) begin
    table_result_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.status = out_bus.status;
      got.slot = out_bus.slot;
      got.value = out_bus.value_out;
      got.live = out_bus.live_entries;
      sb.check_result(got);
    end
    out_bus.ready <= ($urandom_range(99) >= snk_idle);
  end

  task automatic send_req(logic [1:0] mode, logic [KEY_W-1:0] k, logic [KLEN_W-1:0] len,
                          logic [VAL_W-1:0] v);
    while ($urandom_range(99) < src_idle) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.mode <= mode;
    in_bus.key_bytes <= k;
    in_bus.key_length <= len;
    in_bus.value_in <= v;
    do @(posedge clk); while (!in_bus.ready);
    sent++;
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_pool_req();
    int i;
    int len;
    logic [1:0] mode;
    logic [KEY_W-1:0] k;
    i = $urandom_range(POOL - 1);
    len = pool_len[i];
    if (len == KEY_BYTES && $urandom_range(1)) len = $urandom_range(9, 15);
    k = {$urandom, $urandom};
    for (int b = 0; b < KEY_BYTES; b++)
      if (b < pool_len[i]) k[8*b +: 8] = pool_key[i][8*b +: 8];
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5:    mode = MODE_LOOKUP;
      6, 7, 8, 9, 10:      mode = MODE_INSERT;
      11, 12, 13, 14, 15:  mode = MODE_INCREASE;
      default:             mode = MODE_REMOVE;
    endcase
    send_req(mode, k, len[KLEN_W-1:0], rand_value());
  endtask

  initial begin
    sb = new();
    sb.clear();
    cycles = 0;
    sent = 0;
    src_idle = 0;
    snk_idle = 0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.mode = MODE_LOOKUP;
    in_bus.key_bytes = '0;
    in_bus.key_length = '0;
    in_bus.value_in = '0;
    out_bus.ready = 1'b0;
    for (int i = 0; i < POOL; i++) begin
      pool_key[i] = {$urandom, $urandom};
      pool_len[i] = $urandom_range(KEY_BYTES);
    end
    for (int i = 0; i < FILL; i++)
      fill_key[i] = {$urandom, 16'hA55A, i[15:0]};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(MODE_LOOKUP,   64'h0, 4'd0, 32'h0);
    send_req(MODE_INSERT,   64'hDEAD_BEEF_0000_0000, 4'd0, 32'h1234_5678);
    send_req(MODE_INSERT,   64'h0, 4'd0, 32'h9999_9999);
    send_req(MODE_INCREASE, 64'h0, 4'd0, 32'hFFFF_FFFF);
    send_req(MODE_LOOKUP,   64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'h0);
    send_req(MODE_INSERT,   64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'hFFFF_FFFF);
    send_req(MODE_LOOKUP,   64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
    send_req(MODE_INCREASE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 32'h0000_0002);
    send_req(MODE_INSERT,   64'hAAAA_AAAA_AAAA_AA80, 4'd1, 32'h0);
    send_req(MODE_LOOKUP,   64'h5555_5555_5555_5580, 4'd1, 32'h0);
    send_req(MODE_INSERT,   64'h5555_5555_5555_5555, 4'd8, 32'h5555_5555);
    send_req(MODE_INSERT,   64'hAAAA_AAAA_AAAA_AAAA, 4'd8, 32'hAAAA_AAAA);
    send_req(MODE_LOOKUP,   64'h5555_5555_5555_5555, 4'd7, 32'h0);
    send_req(MODE_REMOVE,   64'h0, 4'd0, 32'h0);
    send_req(MODE_REMOVE,   64'h0, 4'd0, 32'h0);
    send_req(MODE_LOOKUP,   64'h0, 4'd0, 32'h0);
    send_req(MODE_INCREASE, 64'h0000_0000_0000_0041, 4'd1, 32'h7FFF_FFFF);
    send_req(MODE_INCREASE, 64'h0000_0000_0000_0041, 4'd1, 32'h8000_0001);
    send_req(MODE_INSERT,   64'h0, 4'd0, 32'h0);
    send_req(MODE_REMOVE,   64'hFFFF_FFFF_FFFF_FFFF, 4'd12, 32'h0);
    send_req(MODE_LOOKUP,   64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
    send_req(MODE_REMOVE,   64'h1234_5678_9ABC_DEF0, 4'd3, 32'h0);

    src_idle = 21;
    snk_idle = 62;
    repeat (450) send_pool_req();

    src_idle = 62;
    snk_idle = 21;
    for (int i = 0; i < FILL; i++)
      send_req(MODE_INSERT, fill_key[i], 4'd8, rand_value());
    for (int i = 0; i < 100; i++) begin
      case ($urandom_range(2))
        0: send_req(MODE_REMOVE, fill_key[$urandom_range(FILL - 1)], 4'd8, 32'h0);
        1: send_req(MODE_INCREASE, fill_key[$urandom_range(FILL - 1)], 4'd8, rand_value());
        default: send_pool_req();
      endcase
    end

    src_idle = 0;
    snk_idle = 0;
    for (int i = 0; i < FILL; i++)
      send_req(MODE_REMOVE, fill_key[i], 4'd8, 32'h0);
    repeat (330) send_pool_req();

    in_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("%0d requests sent, %0d results checked over a fill to capacity and a drain",
             sent, sb.checked);
    $display("results: %0d existed, %0d inserted, %0d not found, %0d full",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("** open_addressing_hash_table: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending.size());
      $display("** open_addressing_hash_table: FAILED **");
    end
    $finish;
  end

endmodule

// File: open_addressing_hash_table.f
rtl/core/oaht_pkg.sv
rtl/core/oaht_if.sv
rtl/core/oaht_ram.sv
rtl/core/open_addressing_hash_table.sv
tb/oaht_tb_pkg.sv
tb/tb_top.sv
